// ----- rtl/core/directed_triangle_census_assert.svh -----
// Assertion macros used by the census top level.
`ifndef DIRECTED_TRIANGLE_CENSUS_ASSERT_SVH
`define DIRECTED_TRIANGLE_CENSUS_ASSERT_SVH

// Clocked check, off while reset is high.
`define DTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, also during reset.
`define DTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/dtc_pkg.sv -----
// Package: sizes, item types and helpers for the triangle census.
`default_nettype none
package dtc_pkg;
  localparam int EDGE_DEPTH = 1024;
  localparam int NBR_DEPTH  = 256;
  localparam int ID_W       = 31;
  localparam int CNT_W      = 17;
  localparam int OP_W       = 2;
  localparam int EDGE_W     = 2 * ID_W;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int EDGE_CW    = $clog2(EDGE_DEPTH + 1);
  localparam int NBR_AW     = $clog2(NBR_DEPTH);
  localparam int NBR_CW     = $clog2(NBR_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
  localparam logic [OP_W-1:0] OP_OUT    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    id_t             vertex_a;
    id_t             vertex_b;
  } in_item_t;

  typedef struct packed {
    count_t in_count;
    count_t out_count;
    count_t through_count;
    count_t cycle_count;
    logic   overflow;
  } result_t;

  typedef struct packed {
    logic  valid;
    edge_t key;
  } srch_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } srch_rsp_t;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/dtc_edge_search.sv -----
// Edge store memory with a sequential halving search.
`default_nettype none
module dtc_edge_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [dtc_pkg::EDGE_AW-1:0] wr_addr,
  input  dtc_pkg::edge_t            wr_data,
  input  logic [dtc_pkg::EDGE_CW-1:0] fill,
  input  dtc_pkg::srch_req_t        req,
  output dtc_pkg::srch_rsp_t        rsp
);
  import dtc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic signed [EDGE_CW:0] STEP_ONE = {{EDGE_CW{1'b0}}, 1'b1};

  edge_t mem [EDGE_DEPTH];
  edge_t rdata;
  edge_t key_r;
  logic [1:0] state;
  logic signed [EDGE_CW:0] lo, hi, mid_r;
  logic signed [EDGE_CW+1:0] sum;
  logic signed [EDGE_CW:0] mid;
  logic [EDGE_AW-1:0] rd_addr;

  assign sum = {lo[EDGE_CW], lo} + {hi[EDGE_CW], hi};
  assign mid = sum[EDGE_CW+1:1];
  assign rd_addr = (lo < hi) ? mid[EDGE_AW-1:0] : lo[EDGE_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            key_r <= req.key;
            if (fill == '0) begin
              rsp.done  <= 1'b1;
              rsp.found <= 1'b0;
            end else begin
              lo    <= '0;
              hi    <= $signed({1'b0, fill}) - STEP_ONE;
              state <= S_LOOP;
            end
          end
        end
        S_LOOP: begin
          mid_r <= mid;
          state <= (lo < hi) ? S_WAIT : S_FIN;
        end
        S_WAIT: begin
          if (rdata < key_r) begin
            lo    <= mid_r + STEP_ONE;
            state <= S_LOOP;
          end else if (rdata > key_r) begin
            hi    <= mid_r - STEP_ONE;
            state <= S_LOOP;
          end else begin
            rsp.done  <= 1'b1;
            rsp.found <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FIN: begin
          rsp.done  <= 1'b1;
          rsp.found <= (rdata == key_r);
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/directed_triangle_census.sv -----
// Top level: load path, neighbor lists and pair-walk sequencer.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  command  | start / busy         | cmd (opcode, vertex_a, vertex_b)
//  result   | result_valid strobe  | result (4 counts, overflow)
//  config   | cfg_valid / cfg_ready| cfg_data (self_vertex)
//
// Load items are taken while idle; busy stays low.
// Finish: per pair, two searches in the edge-store search unit, plus list reads
// (cross-phase pairs of a vertex with itself are skipped); busy high throughout.
// The result strobe is high for one cycle as busy falls; it cannot be held.
// Reset empties all lists and the edge store; config is ready every cycle.
`default_nettype none
module directed_triangle_census (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  dtc_pkg::in_item_t cmd,
  output logic              result_valid,
  output dtc_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  dtc_pkg::id_t      cfg_data
);
  import dtc_pkg::*;
  `include "directed_triangle_census_assert.svh"

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_OUTER   = 4'd1;
  localparam logic [3:0] ST_OUTER_W = 4'd2;
  localparam logic [3:0] ST_INNER   = 4'd3;
  localparam logic [3:0] ST_INNER_W = 4'd4;
  localparam logic [3:0] ST_S1      = 4'd5;
  localparam logic [3:0] ST_S1W     = 4'd6;
  localparam logic [3:0] ST_S2      = 4'd7;
  localparam logic [3:0] ST_S2W     = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  localparam logic [1:0] PH_IN    = 2'd0;
  localparam logic [1:0] PH_OUT   = 2'd1;
  localparam logic [1:0] PH_CROSS = 2'd2;

  id_t in_mem  [NBR_DEPTH];
  id_t out_mem [NBR_DEPTH];
  id_t in_rd, out_rd;

  logic [3:0] state;
  logic [1:0] phase;
  id_t self_vertex;
  logic [EDGE_CW-1:0] edge_fill;
  logic [NBR_CW-1:0] in_fill, out_fill;
  id_t last_src;
  logic last_valid;
  logic ovf;
  logic [NBR_CW-1:0] i, j;
  id_t xa, xb;
  count_t c_in, c_out, c_thr, c_cyc;

  logic accept;
  logic edge_we;
  logic in_add;
  logic [NBR_AW-1:0] rd_addr;
  logic [NBR_CW-1:0] n_a, n_b;
  id_t a_data, b_data;
  srch_req_t sreq;
  srch_rsp_t srsp;
  logic fills_ok;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign edge_we   = accept && (cmd.opcode == OP_EDGE) && (edge_fill < EDGE_CW'(EDGE_DEPTH));
  assign in_add    = accept && (cmd.opcode == OP_EDGE) && (cmd.vertex_b == self_vertex) &&
                     !(last_valid && last_src == cmd.vertex_a);

  assign rd_addr = (state == ST_OUTER) ? i[NBR_AW-1:0] : j[NBR_AW-1:0];
  assign n_a     = (phase == PH_IN) ? in_fill : out_fill;
  assign n_b     = (phase == PH_OUT) ? out_fill : in_fill;
  assign a_data  = (phase == PH_IN) ? in_rd : out_rd;
  assign b_data  = (phase == PH_OUT) ? out_rd : in_rd;

  assign sreq.valid = (state == ST_S1) || (state == ST_S2);
  assign sreq.key   = (state == ST_S1) ? {xa, xb} : {xb, xa};

  dtc_edge_search u_search (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (edge_we),
    .wr_addr (edge_fill[EDGE_AW-1:0]),
    .wr_data ({cmd.vertex_a, cmd.vertex_b}),
    .fill    (edge_fill),
    .req     (sreq),
    .rsp     (srsp)
  );

  always_ff @(posedge clk) begin
    if (in_add && in_fill < NBR_CW'(NBR_DEPTH)) begin
      in_mem[in_fill[NBR_AW-1:0]] <= cmd.vertex_a;
    end
    if (accept && cmd.opcode == OP_OUT && out_fill < NBR_CW'(NBR_DEPTH)) begin
      out_mem[out_fill[NBR_AW-1:0]] <= cmd.vertex_a;
    end
    in_rd  <= in_mem[rd_addr];
    out_rd <= out_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_IN;
      self_vertex  <= '0;
      edge_fill    <= '0;
      in_fill      <= '0;
      out_fill     <= '0;
      last_valid   <= 1'b0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        self_vertex <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.opcode)
              OP_EDGE: begin
                if (edge_we) begin
                  edge_fill <= edge_fill + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
                if (in_add) begin
                  if (in_fill < NBR_CW'(NBR_DEPTH)) begin
                    in_fill <= in_fill + 1'b1;
                  end else begin
                    ovf <= 1'b1;
                  end
                  last_src   <= cmd.vertex_a;
                  last_valid <= 1'b1;
                end
              end
              OP_OUT: begin
                if (out_fill < NBR_CW'(NBR_DEPTH)) begin
                  out_fill <= out_fill + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
              end
              OP_FINISH: begin
                phase <= PH_IN;
                i     <= '0;
                c_in  <= '0;
                c_out <= '0;
                c_thr <= '0;
                c_cyc <= '0;
                state <= ST_OUTER;
              end
              default: ;
            endcase
          end
        end
        ST_OUTER: begin
          if (i < n_a) begin
            state <= ST_OUTER_W;
          end else if (phase == PH_CROSS) begin
            state <= ST_DONE;
          end else begin
            phase <= phase + 1'b1;
            i     <= '0;
          end
        end
        ST_OUTER_W: begin
          xa    <= a_data;
          j     <= (phase == PH_CROSS) ? '0 : i + 1'b1;
          state <= ST_INNER;
        end
        ST_INNER: begin
          if (j < n_b) begin
            state <= ST_INNER_W;
          end else begin
            i     <= i + 1'b1;
            state <= ST_OUTER;
          end
        end
        ST_INNER_W: begin
          xb <= b_data;
          if (phase == PH_CROSS && xa == b_data) begin
            j     <= j + 1'b1;
            state <= ST_INNER;
          end else begin
            state <= ST_S1;
          end
        end
        ST_S1: state <= ST_S1W;
        ST_S1W: begin
          if (srsp.done) begin
            if (srsp.found) begin
              case (phase)
                PH_IN:   c_in  <= sat_inc(c_in);
                PH_OUT:  c_out <= sat_inc(c_out);
                default: c_cyc <= sat_inc(c_cyc);
              endcase
            end
            state <= ST_S2;
          end
        end
        ST_S2: state <= ST_S2W;
        ST_S2W: begin
          if (srsp.done) begin
            if (srsp.found) begin
              case (phase)
                PH_IN:   c_in  <= sat_inc(c_in);
                PH_OUT:  c_out <= sat_inc(c_out);
                default: c_thr <= sat_inc(c_thr);
              endcase
            end
            j     <= j + 1'b1;
            state <= ST_INNER;
          end
        end
        ST_DONE: begin
          result.in_count      <= c_in;
          result.out_count     <= c_out;
          result.through_count <= c_thr;
          result.cycle_count   <= c_cyc;
          result.overflow      <= ovf;
          result_valid         <= 1'b1;
          state                <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign fills_ok = (edge_fill <= EDGE_CW'(EDGE_DEPTH)) &&
                    (in_fill <= NBR_CW'(NBR_DEPTH)) && (out_fill <= NBR_CW'(NBR_DEPTH));

  `DTC_ASSERT(a_result_ends_busy, result_valid |-> $past(busy) && !busy, "result without finish")
  `DTC_ASSERT(a_busy_fall_result, $fell(busy) |-> result_valid, "finish ended without result")
  `DTC_ASSERT_ALWAYS(a_fill_bounds, rst || fills_ok, "fill beyond capacity")
endmodule
`default_nettype wire
